/* rtl/core/twtt_pkg.sv */
package twtt_pkg;

    // Field widths of the transfer payloads
    localparam int FUNC_W    = 2;
    localparam int TIMEOUT_W = 32;
    localparam int HANDLE_W  = 4;
    localparam int STATUS_W  = 2;

    // Table entry rotation field and its saturation value
    localparam int                ROT_W   = 26;
    localparam logic [ROT_W-1:0]  ROT_MAX = {ROT_W{1'b1}};

    // At most this many expiries are reported by one tick
    localparam int RESULT_LIMIT = 16;
    localparam int EXP_CNT_W    = $clog2(RESULT_LIMIT + 1);

    // Slot divider dividend width
    localparam int DIV_W     = 32;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEL  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REJECT     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_ACTIVE = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]           func;
        logic signed [TIMEOUT_W-1:0] timeout;
        logic [HANDLE_W-1:0]         handle_in;
    } twtt_in_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic [STATUS_W-1:0] status;
        logic                expired;
        logic                last;
    } twtt_out_t;

endpackage

/* rtl/core/twtt_slot_div.sv */
module twtt_slot_div #(
    parameter int SLOT_COUNT = 60
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [twtt_pkg::DIV_W-1:0]    dividend,
    output logic                          done,
    output logic [twtt_pkg::DIV_W-1:0]    quotient,
    output logic [$clog2(SLOT_COUNT):0]   remainder
);
    import twtt_pkg::*;

    localparam int REM_W  = $clog2(SLOT_COUNT) + 1;
    localparam int SHIFT  = DIV_W + $clog2(SLOT_COUNT);
    localparam int RCP_W  = DIV_W + 1;
    localparam int PROD_W = DIV_W + RCP_W;
    // Rounded-up reciprocal: exact quotients for every DIV_W-bit dividend
    localparam logic [RCP_W-1:0] RCP =
        RCP_W'(((64'd1 << SHIFT) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT));

    logic [DIV_W-1:0]  num_reg;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic              mul_vld_reg;
    logic              sub_vld_reg;
    logic              done_reg;
    logic [PROD_W-1:0] prod;
    logic [DIV_W-1:0]  back;

    // Scale by the reciprocal and keep the integer part
    assign prod     = PROD_W'(num_reg) * PROD_W'(RCP);
    assign quo_next = DIV_W'(prod >> SHIFT);

    // Take the remainder back from the quotient
    assign back     = DIV_W'(quo_reg * DIV_W'(SLOT_COUNT));
    assign rem_next = REM_W'(num_reg - back);

    // Advance the two pipeline stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
            sub_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            mul_vld_reg <= start;
            sub_vld_reg <= mul_vld_reg;
            done_reg    <= sub_vld_reg;
        end
    end

    // Hold the dividend, quotient and remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
        end
        if (mul_vld_reg) begin
            quo_reg <= quo_next;
        end
        if (sub_vld_reg) begin
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/core/twtt_out_buf.sv */
module twtt_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  twtt_pkg::twtt_out_t push_data,
    output logic                full,
    output logic                m_valid,
    input  logic                m_ready,
    output twtt_pkg::twtt_out_t m_data
);
    import twtt_pkg::*;

    twtt_out_t   head_reg;
    twtt_out_t   tail_reg;
    logic [1:0]  cnt_reg;
    logic        pop;

    assign pop     = m_valid && m_ready;
    assign full    = (cnt_reg == 2'd2);
    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = head_reg;

    // Track occupancy of the two-entry queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            unique case ({push, pop})
                2'b10:   cnt_reg <= 2'(cnt_reg + 1'b1);
                2'b01:   cnt_reg <= 2'(cnt_reg - 1'b1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // Move result payloads: head is presented, tail waits behind it
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (cnt_reg == 2'd2) begin
                head_reg <= tail_reg;
            end else if (push) begin
                head_reg <= push_data;
            end
        end else if (push) begin
            if (cnt_reg == 2'd0) begin
                head_reg <= push_data;
            end else begin
                tail_reg <= push_data;
            end
        end
    end

endmodule

/* rtl/core/timing_wheel_timer_table.sv */
// Delete and rejected operations: result ready in the cycle after the input transfer.
// Add: the result waits on the two-stage reciprocal slot divider.
// Tick: one table entry per cycle through the RAM read port, unless a full result queue stalls the scan.
// One item is worked on at a time; a two-entry result queue lets the next item in.
// Synchronous active-low reset clears the valid bits, the current slot, the
// control state and the result queue; the entry RAM is not cleared.
module timing_wheel_timer_table #(
    parameter int SLOT_COUNT = 60,
    parameter int MAX_TIMERS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  twtt_pkg::twtt_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output twtt_pkg::twtt_out_t m_data
);
    import twtt_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int SUM_W  = SLOT_W + 1;
    localparam int IDX_W  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int ENT_W  = SLOT_W + ROT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t                 state_reg, state_next;
    logic [MAX_TIMERS-1:0]  valid_reg, valid_next;
    logic [SLOT_W-1:0]      cur_reg, cur_next;
    logic [IDX_W-1:0]       free_ix_reg, free_ix_next;
    logic [IDX_W-1:0]       scan_ix_reg, scan_ix_next;
    logic                   issue_done_reg, issue_done_next;
    logic                   stage_vld_reg, stage_vld_next;
    logic [IDX_W-1:0]       stage_ix_reg, stage_ix_next;
    logic                   pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]       pend_ix_reg, pend_ix_next;
    logic [EXP_CNT_W-1:0]   exp_cnt_reg, exp_cnt_next;

    // Entry table memory: {slot, rotation}
    logic [ENT_W-1:0]       ram_mem [MAX_TIMERS];
    logic [ENT_W-1:0]       ram_q_reg;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_wa;
    logic [ENT_W-1:0]       ram_wd;
    logic                   ram_re;
    logic [SLOT_W-1:0]      q_slot;
    logic [ROT_W-1:0]       q_rot;

    logic                   free_found;
    logic [IDX_W-1:0]       free_ix;
    logic                   div_start;
    logic [DIV_W-1:0]       div_dividend;
    logic                   div_done;
    logic [DIV_W-1:0]       div_quo;
    logic [SUM_W-1:0]       div_rem;
    logic [SUM_W-1:0]       slot_sum;
    logic [SUM_W-1:0]       cur_inc;
    logic [SLOT_W-1:0]      new_slot;
    logic [ROT_W-1:0]       new_rot;

    logic                   push;
    twtt_out_t              push_data;
    logic                   fifo_full;
    logic                   accept;
    logic                   del_ok;
    logic                   hit;
    logic                   dec_hit;
    logic                   exp_hit;
    logic                   stall;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE) && !fifo_full;
    assign q_slot  = ram_q_reg[ROT_W +: SLOT_W];
    assign q_rot   = ram_q_reg[ROT_W-1:0];

    // Find the lowest free entry
    always_comb begin
        free_found = 1'b0;
        free_ix    = '0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_ix    = IDX_W'(i);
            end
        end
    end

    // Clamp the timeout to at least one tick before dividing
    assign div_dividend = (s_data.timeout == '0) ? DIV_W'(1) : DIV_W'(s_data.timeout);

    twtt_slot_div #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Place the new entry: saturate the rotation, wrap the slot
    assign slot_sum = SUM_W'({1'b0, cur_reg}) + div_rem;
    assign new_slot = (slot_sum >= SUM_W'(SLOT_COUNT))
                      ? SLOT_W'(slot_sum - SUM_W'(SLOT_COUNT)) : SLOT_W'(slot_sum);
    assign new_rot  = (div_quo > DIV_W'(ROT_MAX)) ? ROT_MAX : div_quo[ROT_W-1:0];
    assign cur_inc  = SUM_W'({1'b0, cur_reg}) + SUM_W'(1);

    // Classify the entry whose read data is now available
    assign hit     = stage_vld_reg && valid_reg[stage_ix_reg] && (q_slot == cur_reg);
    assign dec_hit = hit && (q_rot != '0);
    assign exp_hit = hit && (q_rot == '0) && (exp_cnt_reg < EXP_CNT_W'(RESULT_LIMIT));
    assign stall   = exp_hit && pend_vld_reg && fifo_full;
    assign del_ok  = (32'(s_data.handle_in) < MAX_TIMERS)
                     && valid_reg[IDX_W'(s_data.handle_in)];

    // Sequence operations and table accesses
    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        cur_next        = cur_reg;
        free_ix_next    = free_ix_reg;
        scan_ix_next    = scan_ix_reg;
        issue_done_next = issue_done_reg;
        stage_vld_next  = stage_vld_reg;
        stage_ix_next   = stage_ix_reg;
        pend_vld_next   = pend_vld_reg;
        pend_ix_next    = pend_ix_reg;
        exp_cnt_next    = exp_cnt_reg;
        div_start       = 1'b0;
        ram_we          = 1'b0;
        ram_wa          = stage_ix_reg;
        ram_wd          = {q_slot, ROT_W'(q_rot - 1'b1)};
        ram_re          = 1'b0;
        push            = 1'b0;
        push_data       = '{handle_out: '0, status: STAT_OK, expired: 1'b0, last: 1'b1};

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_data.func)
                        FUNC_ADD: begin
                            if (s_data.timeout[TIMEOUT_W-1] || !free_found) begin
                                push             = 1'b1;
                                push_data.status = STAT_REJECT;
                            end else begin
                                free_ix_next = free_ix;
                                div_start    = 1'b1;
                                state_next   = ST_DIV;
                            end
                        end
                        FUNC_DEL: begin
                            push = 1'b1;
                            if (del_ok) begin
                                valid_next[IDX_W'(s_data.handle_in)] = 1'b0;
                                push_data.handle_out = s_data.handle_in;
                            end else begin
                                push_data.status = STAT_NOT_ACTIVE;
                            end
                        end
                        FUNC_TICK: begin
                            scan_ix_next    = '0;
                            issue_done_next = 1'b0;
                            stage_vld_next  = 1'b0;
                            pend_vld_next   = 1'b0;
                            exp_cnt_next    = '0;
                            state_next      = ST_SCAN;
                        end
                        default: begin
                            push             = 1'b1;
                            push_data.status = STAT_REJECT;
                        end
                    endcase
                end
            end

            ST_DIV: begin
                if (div_done) begin
                    ram_we                  = 1'b1;
                    ram_wa                  = free_ix_reg;
                    ram_wd                  = {new_slot, new_rot};
                    valid_next[free_ix_reg] = 1'b1;
                    push                    = 1'b1;
                    push_data.handle_out    = HANDLE_W'(free_ix_reg);
                    state_next              = ST_IDLE;
                end
            end

            ST_SCAN: begin
                if (!stall) begin
                    // Decrement a waiting entry in place
                    if (dec_hit) begin
                        ram_we = 1'b1;
                    end
                    // Free an expired entry; release the previous expiry
                    if (exp_hit) begin
                        valid_next[stage_ix_reg] = 1'b0;
                        exp_cnt_next             = EXP_CNT_W'(exp_cnt_reg + 1'b1);
                        if (pend_vld_reg) begin
                            push      = 1'b1;
                            push_data = '{handle_out: HANDLE_W'(pend_ix_reg),
                                          status: STAT_OK, expired: 1'b1, last: 1'b0};
                        end
                        pend_vld_next = 1'b1;
                        pend_ix_next  = stage_ix_reg;
                    end
                    // Issue the next read
                    if (!issue_done_reg) begin
                        ram_re         = 1'b1;
                        stage_vld_next = 1'b1;
                        stage_ix_next  = scan_ix_reg;
                        if (scan_ix_reg == IDX_W'(MAX_TIMERS - 1)) begin
                            issue_done_next = 1'b1;
                        end else begin
                            scan_ix_next = IDX_W'(scan_ix_reg + 1'b1);
                        end
                    end else begin
                        stage_vld_next = 1'b0;
                    end
                    if (stage_vld_reg && (stage_ix_reg == IDX_W'(MAX_TIMERS - 1))) begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH: begin
                if (!fifo_full) begin
                    push = 1'b1;
                    if (pend_vld_reg) begin
                        push_data.handle_out = HANDLE_W'(pend_ix_reg);
                        push_data.expired    = 1'b1;
                    end
                    cur_next   = (cur_inc >= SUM_W'(SLOT_COUNT)) ? '0 : SLOT_W'(cur_inc);
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            cur_reg        <= '0;
            issue_done_reg <= 1'b0;
            stage_vld_reg  <= 1'b0;
            pend_vld_reg   <= 1'b0;
            exp_cnt_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            cur_reg        <= cur_next;
            issue_done_reg <= issue_done_next;
            stage_vld_reg  <= stage_vld_next;
            pend_vld_reg   <= pend_vld_next;
            exp_cnt_reg    <= exp_cnt_next;
        end
    end

    // Advance the index registers
    always_ff @(posedge aclk) begin
        free_ix_reg  <= free_ix_next;
        scan_ix_reg  <= scan_ix_next;
        stage_ix_reg <= stage_ix_next;
        pend_ix_reg  <= pend_ix_next;
    end

    // Entry table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (ram_we) begin
            ram_mem[ram_wa] <= ram_wd;
        end
        if (ram_re) begin
            ram_q_reg <= ram_mem[scan_ix_reg];
        end
    end

    twtt_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
